@@ rtl/lmfb_pkg.sv @@
// Shared types, codes and lookup tables for the LED matrix fade/blink driver.
`timescale 1ns / 1ps
package lmfb_pkg;

   // Input opcodes
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes (word address bits [3:2])
   localparam logic [1:0] REG_FADE_STEP    = 2'd0;
   localparam logic [1:0] REG_BLINK_PERIOD = 2'd1;
   localparam logic [1:0] REG_INVERT       = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Fixed field widths
   localparam int LED_INDEX_W = 6;
   localparam int MODE_W      = 4;
   localparam int FADE_W      = 6;
   localparam int COLUMN_W    = 3;
   localparam int ROW_W       = 3;
   localparam int INTENS_W    = 8;
   localparam int PERIOD_W    = 16;

   // Mode bits
   localparam logic [MODE_W-1:0] MODE_STEADY = 4'h1;
   localparam logic [MODE_W-1:0] MODE_BLINK  = 4'h2;
   localparam logic [MODE_W-1:0] MODE_ACTIVE = 4'h4;
   localparam logic [MODE_W-1:0] MODE_PHASE  = 4'h8;
   localparam int MODE_BLINK_BIT = 1;

   localparam logic [INTENS_W-1:0] INTENSITY_MAX = 8'd255;

   // Queue depths between the parts
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Only steady-on and blinking-in-phase-one modes light the LED
   localparam logic [INTENS_W-1:0] LIT_TABLE [0:15] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0
   };

   localparam logic [INTENS_W-1:0] FADE_SCALE [0:63] = '{
      8'd0,   8'd2,   8'd4,   8'd6,   8'd8,   8'd10,  8'd12,  8'd14,
      8'd16,  8'd18,  8'd20,  8'd22,  8'd24,  8'd26,  8'd28,  8'd30,
      8'd32,  8'd34,  8'd36,  8'd38,  8'd40,  8'd42,  8'd44,  8'd46,
      8'd48,  8'd50,  8'd52,  8'd54,  8'd56,  8'd58,  8'd60,  8'd62,
      8'd64,  8'd68,  8'd70,  8'd75,  8'd80,  8'd85,  8'd90,  8'd95,
      8'd100, 8'd105, 8'd110, 8'd115, 8'd120, 8'd125, 8'd130, 8'd135,
      8'd140, 8'd145, 8'd150, 8'd155, 8'd160, 8'd165, 8'd170, 8'd180,
      8'd190, 8'd200, 8'd210, 8'd220, 8'd230, 8'd240, 8'd250, 8'd255
   };

   // Classified command from the front part
   typedef struct packed {
      logic                   tick;
      logic [LED_INDEX_W-1:0] led_index;
      logic [MODE_W-1:0]      mode;
   } cmd_type;

   // One row result
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                row_enabled;
      logic [INTENS_W-1:0] intensity;
      logic                last;
   } rsp_type;

   // Register contents seen by the back part
   typedef struct packed {
      logic [FADE_W-1:0]   fade_step;
      logic [PERIOD_W-1:0] blink_period;
      logic                invert_output;
   } cfg_type;

   // Side effects of register writes
   typedef struct packed {
      logic fade_clear;
      logic counter_clear;
   } csr_evt_type;

endpackage

@@ rtl/led_matrix_fade_blink_driver.sv @@
// Top level of the multiplexed LED matrix driver with per-LED blink and fade.
`timescale 1ns / 1ps
// Set beat: the back part pops it from the command queue, reads the old mode in ST_IDLE and
//   writes the new mode in ST_SET (no result). Tick beat: a ST_ROW_RD/ST_ROW_WR pair per row,
//   after a blink refresh sweep over all LEDs when due; each row beat goes through the result
//   queue to the result ports, and ST_ROW_WR waits while that queue is full.
// Reset: synchronous, clears control state; LED modes and fade levels read as zero
//   through per-entry valid bits, so no clearing pass is run.
module led_matrix_fade_blink_driver #(
   parameter int LED_COLUMNS = 8,
   parameter int LED_ROWS    = 6,
   parameter int FADE_LEVELS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request queue side
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_opcode,
   input  logic [lmfb_pkg::LED_INDEX_W-1:0] req_led_index,
   input  logic                             req_led_on,
   input  logic                             req_blink_mode,
   // Result queue side
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [lmfb_pkg::COLUMN_W-1:0]    rsp_column,
   output logic [lmfb_pkg::ROW_W-1:0]       rsp_row,
   output logic                             rsp_row_enabled,
   output logic [lmfb_pkg::INTENS_W-1:0]    rsp_intensity,
   output logic                             rsp_last,
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lmfb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lmfb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lmfb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import lmfb_pkg::*;

   localparam int LED_TOTAL = LED_ROWS * LED_COLUMNS;

   // Register file
   logic [FADE_W-1:0]   fade_step_ff, fade_step_in;
   logic [PERIOD_W-1:0] blink_period_ff, blink_period_in;
   logic                invert_ff, invert_in;
   logic                csr_wr;
   logic [1:0]          csr_index;
   cfg_type             cfg;
   csr_evt_type         csr_evt;

   // Front-to-back command queue
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_front, cmd_back;

   // Back-to-port result queue
   logic    rsp_push, rsp_full;
   rsp_type rsp_back, rsp_head;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write beat: update the addressed register; unknown indexes do nothing
   always_comb begin
      fade_step_in    = fade_step_ff;
      blink_period_in = blink_period_ff;
      invert_in       = invert_ff;
      csr_evt         = '0;
      if (csr_wr) begin
         unique case (csr_index)
            REG_FADE_STEP: begin
               fade_step_in       = csr_pwdata[FADE_W-1:0];
               csr_evt.fade_clear = 1'b1;
            end
            REG_BLINK_PERIOD: begin
               blink_period_in       = csr_pwdata[PERIOD_W-1:0];
               csr_evt.counter_clear = 1'b1;
            end
            REG_INVERT: begin
               invert_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read beat: return the addressed register, zero-extended
   always_comb begin
      unique case (csr_index)
         REG_FADE_STEP:    csr_prdata = CSR_DATA_W'(fade_step_ff);
         REG_BLINK_PERIOD: csr_prdata = CSR_DATA_W'(blink_period_ff);
         REG_INVERT:       csr_prdata = CSR_DATA_W'(invert_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_step_ff    <= '0;
         blink_period_ff <= '0;
         invert_ff       <= 1'b0;
      end else begin
         fade_step_ff    <= fade_step_in;
         blink_period_ff <= blink_period_in;
         invert_ff       <= invert_in;
      end
   end

   assign cfg.fade_step     = fade_step_ff;
   assign cfg.blink_period  = blink_period_ff;
   assign cfg.invert_output = invert_ff;

   // Classify request beats and drop sets that fall outside the matrix
   lmfb_front #(.LED_TOTAL(LED_TOTAL)) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_led_index  (req_led_index),
      .req_led_on     (req_led_on),
      .req_blink_mode (req_blink_mode),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_front)
   );

   // Short queue so the front keeps taking beats while the back is busy
   lmfb_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_front),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_back),
      .empty     (cmd_empty)
   );

   // Mode/fade storage, blink refresh sweep and per-row drive computation
   lmfb_back #(
      .LED_COLUMNS (LED_COLUMNS),
      .LED_ROWS    (LED_ROWS),
      .FADE_LEVELS (FADE_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .csr_evt   (csr_evt),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_back),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_back)
   );

   // Result queue: hold finished rows until the consumer pops them
   lmfb_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_back),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_column      = rsp_head.column;
   assign rsp_row         = rsp_head.row;
   assign rsp_row_enabled = rsp_head.row_enabled;
   assign rsp_intensity   = rsp_head.intensity;
   assign rsp_last        = rsp_head.last;

endmodule

@@ rtl/lmfb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lmfb_fifo.sv @@
// Small register FIFO used between the front, the back and the result port.
`timescale 1ns / 1ps
module lmfb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lmfb_front.sv @@
// Front part: accept request beats, drop out-of-range sets, encode the new LED mode.
`timescale 1ns / 1ps
module lmfb_front #(
   parameter int LED_TOTAL = 48
) (
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_opcode,
   input  logic [lmfb_pkg::LED_INDEX_W-1:0] req_led_index,
   input  logic                            req_led_on,
   input  logic                            req_blink_mode,
   input  logic                            cmd_full,
   output logic                            cmd_push,
   output lmfb_pkg::cmd_type               cmd
);
   import lmfb_pkg::*;

   logic is_tick;
   logic in_range;

   assign is_tick  = (req_opcode == OP_TICK);
   assign in_range = ({3'b000, req_led_index} < 9'(LED_TOTAL));
   assign req_full = cmd_full;
   // A set beyond the matrix is accepted and dropped here
   assign cmd_push = req_push && !cmd_full && (is_tick || in_range);

   always_comb begin
      cmd.tick      = is_tick;
      cmd.led_index = req_led_index;
      if (!req_led_on) begin
         cmd.mode = '0;
      end else if (req_blink_mode) begin
         cmd.mode = MODE_ACTIVE | MODE_BLINK | MODE_PHASE;
      end else begin
         cmd.mode = MODE_ACTIVE | MODE_STEADY;
      end
   end

endmodule

@@ rtl/lmfb_back.sv @@
// Back part: mode/fade storage, blink sweep, per-row fade ramp and result generation.
`timescale 1ns / 1ps
module lmfb_back #(
   parameter int LED_COLUMNS = 8,
   parameter int LED_ROWS    = 6,
   parameter int FADE_LEVELS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmfb_pkg::cfg_type     cfg,
   input  lmfb_pkg::csr_evt_type csr_evt,
   input  logic                  cmd_empty,
   input  lmfb_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output lmfb_pkg::rsp_type     rsp
);
   import lmfb_pkg::*;

   localparam int LED_TOTAL = LED_ROWS * LED_COLUMNS;
   localparam int AW  = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
   localparam int CW  = (LED_COLUMNS > 1) ? $clog2(LED_COLUMNS) : 1;
   localparam int RW  = (LED_ROWS > 1) ? $clog2(LED_ROWS) : 1;
   localparam int BCW = $clog2(LED_TOTAL + 1);

   localparam logic [AW:0]       SWEEP_END = (AW + 1)'(LED_TOTAL);
   localparam logic [AW-1:0]     COL_STEP  = AW'(LED_COLUMNS);
   localparam logic [CW-1:0]     COL_LAST  = CW'(LED_COLUMNS - 1);
   localparam logic [RW-1:0]     ROW_LAST  = RW'(LED_ROWS - 1);
   localparam logic [FADE_W-1:0] FADE_TOP  = FADE_W'(FADE_LEVELS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SET    = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_ROW_RD = 3'd3;
   localparam logic [2:0] ST_ROW_WR = 3'd4;

   logic [2:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW:0]         sweep_cnt_ff, sweep_cnt_in;
   logic                sweep_pend_ff, sweep_pend_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [PERIOD_W-1:0] counter_ff, counter_in;
   logic                phase_ff, phase_in;
   logic                active_ff, active_in;
   logic [BCW-1:0]      bcount_ff, bcount_in;
   logic [LED_TOTAL-1:0] mode_vld_ff, mode_vld_in;
   logic [LED_TOTAL-1:0] fade_vld_ff, fade_vld_in;
   logic                mode_rvld_ff, mode_rvld_in;
   logic                fade_rvld_ff, fade_rvld_in;

   logic                mode_rd_en, mode_wr_en;
   logic [AW-1:0]       mode_rd_addr, mode_wr_addr;
   logic [MODE_W-1:0]   mode_rd_data, mode_wr_data;
   logic                fade_rd_en, fade_wr_en;
   logic [FADE_W-1:0]   fade_rd_data;

   logic [MODE_W-1:0]   mode_eff;
   logic [FADE_W-1:0]   fade_eff;
   logic                lit;
   logic [FADE_W:0]     lv_sum;
   logic [FADE_W-1:0]   lv_new;
   logic                row_en;
   logic [INTENS_W-1:0] row_val;
   logic [BCW-1:0]      bcount_new;
   logic [PERIOD_W-1:0] counter_inc;

   lmfb_ram #(.WIDTH(MODE_W), .DEPTH(LED_TOTAL), .AW(AW)) u_mode_ram (
      .clock   (clock),
      .wr_en   (mode_wr_en),
      .wr_addr (mode_wr_addr),
      .wr_data (mode_wr_data),
      .rd_en   (mode_rd_en),
      .rd_addr (mode_rd_addr),
      .rd_data (mode_rd_data)
   );

   lmfb_ram #(.WIDTH(FADE_W), .DEPTH(LED_TOTAL), .AW(AW)) u_fade_ram (
      .clock   (clock),
      .wr_en   (fade_wr_en),
      .wr_addr (addr_ff),
      .wr_data (lv_new),
      .rd_en   (fade_rd_en),
      .rd_addr (addr_ff),
      .rd_data (fade_rd_data)
   );

   // Unwritten entries read as reset values: mode off, fade level zero
   assign mode_eff = mode_rvld_ff ? mode_rd_data : '0;
   assign fade_eff = fade_rvld_ff ? fade_rd_data : '0;
   assign lit      = (LIT_TABLE[mode_eff] != '0);
   assign lv_sum   = {1'b0, fade_eff} + {1'b0, cfg.fade_step};

   // Fade ramp and intensity for the row being read
   always_comb begin
      lv_new  = fade_eff;
      row_en  = 1'b0;
      row_val = '0;
      if (cfg.fade_step == '0 && lit) begin
         row_en  = 1'b1;
         row_val = INTENSITY_MAX;
      end else begin
         if (lit && fade_eff != FADE_TOP) begin
            lv_new = (lv_sum > {1'b0, FADE_TOP}) ? FADE_TOP : lv_sum[FADE_W-1:0];
         end else if (!lit && fade_eff != '0) begin
            lv_new = (fade_eff > cfg.fade_step) ? fade_eff - cfg.fade_step : '0;
         end
         if (lv_new != '0) begin
            row_en  = 1'b1;
            row_val = FADE_SCALE[lv_new];
         end
      end
      if (row_en && cfg.invert_output) begin
         row_val = INTENSITY_MAX - row_val;
      end
   end

   assign rsp.column      = COLUMN_W'(col_ff);
   assign rsp.row         = ROW_W'(row_ff);
   assign rsp.row_enabled = row_en;
   assign rsp.intensity   = row_val;
   assign rsp.last        = (row_ff == ROW_LAST);

   assign bcount_new  = bcount_ff - BCW'(mode_eff[MODE_BLINK_BIT])
                        + BCW'(cmd_ff.mode[MODE_BLINK_BIT]);
   assign counter_inc = counter_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      addr_in       = addr_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_pend_in = 1'b0;
      sweep_addr_in = sweep_addr_ff;
      counter_in    = counter_ff;
      phase_in      = phase_ff;
      active_in     = active_ff;
      bcount_in     = bcount_ff;
      cmd_pop       = 1'b0;
      mode_rd_en    = 1'b0;
      mode_rd_addr  = addr_ff;
      mode_wr_en    = 1'b0;
      mode_wr_addr  = addr_ff;
      mode_wr_data  = cmd_ff.mode;
      fade_rd_en    = 1'b0;
      fade_wr_en    = 1'b0;
      rsp_push      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.tick) begin
                  row_in  = '0;
                  addr_in = AW'(col_ff);
                  if (active_ff && counter_ff == '0) begin
                     sweep_cnt_in = '0;
                     state_in     = ST_SWEEP;
                  end else begin
                     state_in = ST_ROW_RD;
                  end
               end else begin
                  mode_rd_en   = 1'b1;
                  mode_rd_addr = AW'(cmd.led_index);
                  addr_in      = AW'(cmd.led_index);
                  state_in     = ST_SET;
               end
            end
         end
         ST_SET: begin
            mode_wr_en = 1'b1;
            bcount_in  = bcount_new;
            if (bcount_new != '0) begin
               if (!active_ff) begin
                  active_in  = 1'b1;
                  phase_in   = 1'b1;
                  counter_in = '0;
               end
            end else if (active_ff) begin
               active_in  = 1'b0;
               phase_in   = 1'b1;
               counter_in = '0;
            end
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            // Read entry n while writing back entry n-1
            if (sweep_cnt_ff < SWEEP_END) begin
               mode_rd_en    = 1'b1;
               mode_rd_addr  = sweep_cnt_ff[AW-1:0];
               sweep_pend_in = 1'b1;
               sweep_addr_in = sweep_cnt_ff[AW-1:0];
            end
            if (sweep_pend_ff && mode_eff[MODE_BLINK_BIT]) begin
               mode_wr_en   = 1'b1;
               mode_wr_addr = sweep_addr_ff;
               mode_wr_data = {phase_ff, mode_eff[MODE_W-2:0]};
            end
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == SWEEP_END) begin
               phase_in = !phase_ff;
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            mode_rd_en = 1'b1;
            fade_rd_en = 1'b1;
            state_in   = ST_ROW_WR;
         end
         ST_ROW_WR: begin
            if (!rsp_full) begin
               rsp_push   = 1'b1;
               fade_wr_en = 1'b1;
               if (row_ff == ROW_LAST) begin
                  if (active_ff) begin
                     counter_in = (counter_inc >= cfg.blink_period) ? '0 : counter_inc;
                  end
                  col_in   = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  addr_in  = addr_ff + COL_STEP;
                  state_in = ST_ROW_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_evt.counter_clear) begin
         counter_in = '0;
      end
   end

   always_comb begin
      mode_vld_in  = mode_vld_ff;
      fade_vld_in  = fade_vld_ff;
      mode_rvld_in = mode_rvld_ff;
      fade_rvld_in = fade_rvld_ff;
      if (mode_wr_en) begin
         mode_vld_in[mode_wr_addr] = 1'b1;
      end
      if (csr_evt.fade_clear) begin
         fade_vld_in = '0;
      end else if (fade_wr_en) begin
         fade_vld_in[addr_ff] = 1'b1;
      end
      if (mode_rd_en) begin
         mode_rvld_in = mode_vld_ff[mode_rd_addr];
      end
      if (fade_rd_en) begin
         fade_rvld_in = fade_vld_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         sweep_cnt_ff  <= '0;
         sweep_pend_ff <= 1'b0;
         counter_ff    <= '0;
         phase_ff      <= 1'b1;
         active_ff     <= 1'b0;
         bcount_ff     <= '0;
         mode_vld_ff   <= '0;
         fade_vld_ff   <= '0;
         mode_rvld_ff  <= 1'b0;
         fade_rvld_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_pend_ff <= sweep_pend_in;
         counter_ff    <= counter_in;
         phase_ff      <= phase_in;
         active_ff     <= active_in;
         bcount_ff     <= bcount_in;
         mode_vld_ff   <= mode_vld_in;
         fade_vld_ff   <= fade_vld_in;
         mode_rvld_ff  <= mode_rvld_in;
         fade_rvld_ff  <= fade_rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      sweep_addr_ff <= sweep_addr_in;
   end

endmodule

@@ dv/led_matrix_fade_blink_driver_test.sv @@
// Self-checking testbench for the LED matrix fade/blink driver, checked row beat by row beat.
`timescale 1ns / 1ps
module led_matrix_fade_blink_driver_test;
   import lmfb_pkg::*;

   // Matrix geometry, kept equal to the instance parameters below
   localparam int LED_COLUMNS = 8;
   localparam int LED_ROWS    = 6;
   localparam int FADE_LEVELS = 64;
   localparam int LED_TOTAL   = LED_ROWS * LED_COLUMNS;
   localparam int FADE_TOP    = FADE_LEVELS - 1;

   // Idle time before a register write: covers a tick with a full blink sweep
   localparam int SETTLE_CYCLES = 150;
   // Watchdog bound for the whole run, with margin above the slowest legal run
   localparam int CYCLE_LIMIT   = 400000;
   // Register slot with nothing behind it
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic                   opcode;
      logic [LED_INDEX_W-1:0] led_index;
      logic                   led_on;
      logic                   blink_mode;
   } matrix_cmd_type;

   // Block inputs start at known values
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_push       = 1'b0;
   logic                   req_opcode     = OP_SET;
   logic [LED_INDEX_W-1:0] req_led_index  = '0;
   logic                   req_led_on     = 1'b0;
   logic                   req_blink_mode = 1'b0;
   logic                   rsp_pop        = 1'b0;
   logic                   csr_psel       = 1'b0;
   logic                   csr_penable    = 1'b0;
   logic                   csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr      = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata     = '0;

   logic                   req_full;
   logic                   rsp_empty;
   logic [COLUMN_W-1:0]    rsp_column;
   logic [ROW_W-1:0]       rsp_row;
   logic                   rsp_row_enabled;
   logic [INTENS_W-1:0]    rsp_intensity;
   logic                   rsp_last;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   led_matrix_fade_blink_driver #(
      .LED_COLUMNS(LED_COLUMNS),
      .LED_ROWS   (LED_ROWS),
      .FADE_LEVELS(FADE_LEVELS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_led_index  (req_led_index),
      .req_led_on     (req_led_on),
      .req_blink_mode (req_blink_mode),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_row_enabled(rsp_row_enabled),
      .rsp_intensity  (rsp_intensity),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Mirror of the driver state and its registers, at reset values
   // ------------------------------------------------------------------
   logic [MODE_W-1:0]   mode_mirror  [LED_TOTAL] = '{default: '0};
   logic [FADE_W-1:0]   level_mirror [LED_TOTAL] = '{default: '0};
   int                  scan_col_mirror    = 0;
   logic [PERIOD_W-1:0] blink_count_mirror = '0;
   logic                blink_phase_mirror = 1'b1;
   logic                blink_on_mirror    = 1'b0;
   int                  blinking_leds      = 0;
   logic [FADE_W-1:0]   fade_step_mirror   = '0;
   logic [PERIOD_W-1:0] period_mirror      = '0;
   logic                invert_mirror      = 1'b0;

   // Row beats predicted but not yet popped, oldest first
   rsp_type rows_due [$];

   int  mismatch_count = 0;
   int  rows_seen      = 0;
   int  items_sent     = 0;
   int  ticks_sent     = 0;
   int  reg_writes     = 0;
   int  cycle_count    = 0;
   int  pop_stall_left = 0;
   bit  idling_on      = 1'b1;

   // Register write side effects: fade step wipes every level, period restarts the counter
   task automatic apply_reg_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_FADE_STEP: begin
            level_mirror     = '{default: '0};
            fade_step_mirror = value[FADE_W-1:0];
         end
         REG_BLINK_PERIOD: begin
            period_mirror      = value[PERIOD_W-1:0];
            blink_count_mirror = '0;
         end
         REG_INVERT: invert_mirror = value[0];
         default: ;
      endcase
   endtask

   // Enable blinking only on the transition from off; a running blink keeps its phase
   task automatic arm_blink();
      if (!blink_on_mirror) begin
         blink_on_mirror    = 1'b1;
         blink_phase_mirror = 1'b1;
         blink_count_mirror = '0;
      end
   endtask

   // Advance the mirror by one accepted beat and queue the row beats it causes
   task automatic predict_matrix_item(input matrix_cmd_type cmd);
      logic [MODE_W-1:0] next_mode;
      int                col;
      int                led;
      int                level;
      logic              lit;
      rsp_type           row_beat;
      if (cmd.opcode == OP_SET) begin
         // Out-of-range index: drop the beat, state untouched
         if (cmd.led_index < LED_TOTAL) begin
            if (!cmd.led_on)
               next_mode = '0;
            else if (cmd.blink_mode)
               next_mode = MODE_ACTIVE | MODE_BLINK | MODE_PHASE;
            else
               next_mode = MODE_ACTIVE | MODE_STEADY;
            if ((mode_mirror[cmd.led_index] & MODE_BLINK) != 0)
               blinking_leds--;
            if ((next_mode & MODE_BLINK) != 0)
               blinking_leds++;
            mode_mirror[cmd.led_index] = next_mode;
            if (cmd.led_on && cmd.blink_mode)
               arm_blink();
            else if (blinking_leds != 0)
               arm_blink();
            else if (blink_on_mirror) begin
               // Last blinking LED gone: park the blink logic
               blink_phase_mirror = 1'b1;
               blink_count_mirror = '0;
               blink_on_mirror    = 1'b0;
            end
         end
      end else begin
         col = scan_col_mirror;
         // Refresh the phase copy of every blinking LED when the counter is at zero
         if (blink_on_mirror && blink_count_mirror == '0) begin
            for (int i = 0; i < LED_TOTAL; i++) begin
               if ((mode_mirror[i] & MODE_BLINK) != 0)
                  mode_mirror[i][3] = blink_phase_mirror;
            end
            blink_phase_mirror = ~blink_phase_mirror;
         end
         for (int r = 0; r < LED_ROWS; r++) begin
            led                  = col + r * LED_COLUMNS;
            lit                  = LIT_TABLE[mode_mirror[led]] != '0;
            row_beat.column      = COLUMN_W'(col);
            row_beat.row         = ROW_W'(r);
            row_beat.row_enabled = 1'b0;
            row_beat.intensity   = '0;
            row_beat.last        = (r == LED_ROWS - 1);
            if (fade_step_mirror == '0 && lit) begin
               row_beat.row_enabled = 1'b1;
               row_beat.intensity   = INTENSITY_MAX;
            end else begin
               // Ramp toward full or dark, saturating at the ends
               level = int'(level_mirror[led]);
               if (lit && level != FADE_TOP) begin
                  level = level + int'(fade_step_mirror);
                  if (level > FADE_TOP)
                     level = FADE_TOP;
               end else if (!lit && level != 0) begin
                  level = (level > int'(fade_step_mirror)) ?
                          level - int'(fade_step_mirror) : 0;
               end
               level_mirror[led] = FADE_W'(level);
               if (level != 0) begin
                  row_beat.row_enabled = 1'b1;
                  row_beat.intensity   = FADE_SCALE[level];
               end
            end
            // Undriven rows stay at zero even with inversion on
            if (row_beat.row_enabled && invert_mirror)
               row_beat.intensity = INTENSITY_MAX - row_beat.intensity;
            rows_due.push_back(row_beat);
         end
         if (blink_on_mirror) begin
            blink_count_mirror = blink_count_mirror + 1'b1;
            if (blink_count_mirror >= period_mirror)
               blink_count_mirror = '0;
         end
         scan_col_mirror = (col + 1) % LED_COLUMNS;
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random pop stalls and the row beat checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (pop_stall_left > 0) begin
         rsp_pop        <= 1'b0;
         pop_stall_left <= pop_stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         // Start a stall burst
         rsp_pop        <= 1'b0;
         pop_stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"[%0t] %s: expected col %0d row %0d en %0d int %0d last %0d,",
                   " got col %0d row %0d en %0d int %0d last %0d"},
                  $realtime, what, want.column, want.row, want.row_enabled, want.intensity,
                  want.last, got.column, got.row, got.row_enabled, got.intensity, got.last);
   endtask

   rsp_type row_got;
   rsp_type row_want;

   // Compare each popped row beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         row_got.column      = rsp_column;
         row_got.row         = rsp_row;
         row_got.row_enabled = rsp_row_enabled;
         row_got.intensity   = rsp_intensity;
         row_got.last        = rsp_last;
         rows_seen++;
         if (rows_due.size() == 0) begin
            note_mismatch("row beat with nothing due", '0, row_got);
         end else begin
            row_want = rows_due.pop_front();
            if (row_got.column !== row_want.column || row_got.row !== row_want.row ||
                row_got.row_enabled !== row_want.row_enabled ||
                row_got.intensity !== row_want.intensity || row_got.last !== row_want.last)
               note_mismatch("row beat mismatch", row_want, row_got);
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles, %0d row beats still due",
                  cycle_count, rows_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers; every task starts and ends just after a falling edge
   // ------------------------------------------------------------------

   // Drive one beat, hold it until accepted, then maybe idle for a burst
   task automatic send_item(input logic op, input logic [LED_INDEX_W-1:0] idx,
                            input logic on, input logic blink);
      matrix_cmd_type cmd;
      cmd            = '{op, idx, on, blink};
      req_push       <= 1'b1;
      req_opcode     <= op;
      req_led_index  <= idx;
      req_led_on     <= on;
      req_blink_mode <= blink;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_matrix_item(cmd);
      items_sent++;
      if (op == OP_TICK)
         ticks_sent++;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   // Drop push, wait for every due row beat, then let the back part finish up
   task automatic wait_idle();
      req_push <= 1'b0;
      while (rows_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup cycle, access cycle, then release the bus
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_reg_write(idx, value);
      reg_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram all registers while idle, then stream random beats:
   // mostly ticks and in-range sets, with some out-of-range sets mixed in
   task automatic run_random_phase(input int fade, input int period, input int inv,
                                   input int count);
      logic [LED_INDEX_W-1:0] idx;
      wait_idle();
      write_reg(REG_FADE_STEP, fade);
      write_reg(REG_BLINK_PERIOD, period);
      write_reg(REG_INVERT, inv);
      repeat (count) begin
         if ($urandom_range(0, 99) < 55) begin
            // Set fields carry junk on a tick; the block must ignore them
            send_item(OP_TICK, LED_INDEX_W'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 11) == 0)
               idx = LED_INDEX_W'($urandom_range(LED_TOTAL, 63));
            else
               idx = LED_INDEX_W'($urandom_range(0, LED_TOTAL - 1));
            send_item(OP_SET, idx, $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: steady and blinking LEDs, ignored indexes, one full column sweep
   task automatic test_scan_and_blink();
      send_item(OP_SET, 6'd0, 1'b1, 1'b0);
      send_item(OP_SET, 6'd47, 1'b1, 1'b1);
      send_item(OP_SET, 6'd48, 1'b1, 1'b0);
      send_item(OP_SET, 6'd63, 1'b1, 1'b1);
      // Period zero: refresh and toggle the phase on every tick
      repeat (LED_COLUMNS) send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
      // Blink requested while off: the last blinker goes, blinking stops
      send_item(OP_SET, 6'd47, 1'b0, 1'b1);
      send_item(OP_SET, 6'd5, 1'b1, 1'b0);
      // Hold the sender until every row beat is back
      wait_idle();
   endtask

   // Largest fade step with inversion: levels jump straight to the ends
   task automatic test_fade_and_invert();
      wait_idle();
      write_reg(REG_FADE_STEP, FADE_TOP);
      write_reg(REG_BLINK_PERIOD, 1);
      write_reg(REG_INVERT, 1);
      send_item(OP_SET, 6'd9, 1'b1, 1'b0);
      send_item(OP_SET, 6'd17, 1'b1, 1'b1);
      repeat (LED_COLUMNS) send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
   endtask

   // Random traffic across a spread of register settings, with idling on both sides
   task automatic test_random_configs();
      run_random_phase(0, 0, 0, 64);
      run_random_phase(1, 3, 0, 64);
      run_random_phase(FADE_TOP, 1, 1, 64);
      run_random_phase($urandom_range(2, 20), 16'hFFFF, $urandom_range(0, 1), 64);
      // A write to the empty slot must change nothing
      wait_idle();
      write_reg(REG_UNMAPPED, $urandom);
      run_random_phase($urandom_range(0, FADE_TOP), $urandom_range(2, 12),
                       $urandom_range(0, 1), 64);
   endtask

   // Closing stretch with no idling on either side
   task automatic test_back_to_back();
      wait_idle();
      idling_on = 1'b0;
      run_random_phase($urandom_range(1, 8), $urandom_range(0, 5), 0, 36);
   endtask

   initial begin
      // Hold reset from time zero, release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_scan_and_blink();
      test_fade_and_invert();
      test_random_configs();
      test_back_to_back();

      wait_idle();
      $display("Covered %0d beats (%0d scan ticks), %0d row beats checked, %0d register writes.",
               items_sent, ticks_sent, rows_seen, reg_writes);
      $display("Fade steps 0 to 63, blink periods 0 to 65535, both polarities; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
